FILE: sv/snpr_pkg.sv
package snpr_pkg;

    localparam int SEQ_W = 24;
    localparam logic [SEQ_W-1:0] FUTURE_LIMIT = 24'h7F_FFFF;

    localparam logic [127:0] HEX_DIGITS = "0123456789ABCDEF";
    localparam logic [7:0] CHAR_S = "S";
    localparam logic [7:0] CHAR_L = "L";
    localparam logic [3:0] NIB_MASK = 4'hF;

    typedef enum logic {
        REQ_PUSH = 1'b0,
        REQ_READ = 1'b1
    } t_req;

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_FUTURE  = 3'd1,
        STAT_TOO_OLD = 3'd2,
        STAT_PUSHED  = 3'd3,
        STAT_BUSY    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_STREAM
    } t_state;

    typedef struct packed {
        t_req             req_type;
        logic [63:0]      record_word;
        logic [SEQ_W-1:0] seq_request;
    } t_in_beat;

    typedef struct packed {
        t_status          status;
        logic [SEQ_W-1:0] seq_number;
        logic [63:0]      header_word;
        logic [63:0]      data_word;
        logic             last;
    } t_out_beat;

endpackage

FILE: sv/seq_numbered_packet_ring.sv
// Ring of SLOT_COUNT records of RECORD_WORDS 64-bit words, held in one
// single-port-read RAM addressed {slot, word}. A push takes one beat per cycle
// while out_free holds; the last word of a record commits it and returns its
// 24-bit sequence number. A busy or empty reply to a read is registered on the
// accepting edge. Any other read first passes the window check in S_CALC; a
// miss reply is then presented, while a hit streams RECORD_WORDS beats, each
// carrying the header, at one per cycle while the output is not stalled, after
// a registered RAM read. No new beat is taken while a read reply is in
// flight. There is no clearing pass after reset.
module seq_numbered_packet_ring #(
    parameter int SLOT_COUNT   = 64,
    parameter int RECORD_WORDS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  snpr_pkg::t_in_beat   i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output snpr_pkg::t_out_beat  o_out_beat
);

    localparam int SW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int WW    = (RECORD_WORDS > 1) ? $clog2(RECORD_WORDS) : 1;
    localparam int CW    = $clog2(SLOT_COUNT + 1);
    localparam int AW    = SW + WW;
    localparam int DEPTH = 1 << AW;
    localparam int SEQ_W = snpr_pkg::SEQ_W;

    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);
    localparam logic [SW:0]   SC_W      = (SW + 1)'(SLOT_COUNT);
    localparam logic [WW-1:0] LAST_WORD = WW'(RECORD_WORDS - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(SLOT_COUNT);

    function automatic logic [63:0] make_header(input logic [SEQ_W-1:0] seq);
        logic [63:0] h;
        logic [3:0]  nib;
        h = {48'd0, snpr_pkg::CHAR_L, snpr_pkg::CHAR_S};
        for (int i = 0; i < 6; i++) begin
            nib = 4'(seq >> (4 * (5 - i))) & snpr_pkg::NIB_MASK;
            h[8*(2+i) +: 8] = snpr_pkg::HEX_DIGITS[8*(15 - int'(nib)) +: 8];
        end
        return h;
    endfunction

    logic [63:0] r_mem [0:DEPTH-1];
    logic [63:0] r_mem_q;

    snpr_pkg::t_state    r_state, n_state;
    logic [SW-1:0]       r_head, n_head;
    logic [SW-1:0]       r_tail, n_tail;
    logic [CW-1:0]       r_held, n_held;
    logic [SEQ_W-1:0]    r_next_seq, n_next_seq;
    logic [SEQ_W-1:0]    r_oldest, n_oldest;
    logic [WW-1:0]       r_widx, n_widx;
    logic [SEQ_W-1:0]    r_seq, n_seq;
    logic [SEQ_W-1:0]    r_fwd, n_fwd;
    logic [SW-1:0]       r_slot, n_slot;
    logic [63:0]         r_hdr, n_hdr;
    logic [WW-1:0]       r_rd_idx, n_rd_idx;
    logic                r_issuing, n_issuing;
    logic                r_q_vld, n_q_vld;
    logic                r_q_last, n_q_last;
    logic                r_out_valid, n_out_valid;
    snpr_pkg::t_out_beat r_out, n_out;

    logic            out_free;
    logic            in_ready;
    logic            mem_wr;
    logic [AW-1:0]   mem_waddr;
    logic            mem_rd;
    logic [AW-1:0]   mem_raddr;
    logic            in_win;
    logic [SW:0]     slot_sum;

    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem[mem_waddr] <= i_in_beat.record_word;
        end
        if (mem_rd) begin
            r_mem_q <= r_mem[mem_raddr];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_held      = r_held;
        n_next_seq  = r_next_seq;
        n_oldest    = r_oldest;
        n_widx      = r_widx;
        n_seq       = r_seq;
        n_fwd       = r_fwd;
        n_slot      = r_slot;
        n_hdr       = r_hdr;
        n_rd_idx    = r_rd_idx;
        n_issuing   = r_issuing;
        n_q_vld     = r_q_vld;
        n_q_last    = r_q_last;
        n_out       = r_out;
        out_free    = !r_out_valid || i_out_ready;
        n_out_valid = r_out_valid && !i_out_ready;
        in_ready    = 1'b0;
        mem_wr      = 1'b0;
        mem_waddr   = {r_head, r_widx};
        mem_rd      = 1'b0;
        mem_raddr   = {r_slot, r_rd_idx};
        in_win      = r_fwd < SEQ_W'(r_held);
        slot_sum    = {1'b0, r_tail} + {1'b0, r_fwd[SW-1:0]};
        if (slot_sum >= SC_W) begin
            slot_sum = slot_sum - SC_W;
        end

        unique case (r_state)
            snpr_pkg::S_IDLE: begin
                in_ready = out_free;
                if (i_in_valid && out_free) begin
                    if (i_in_beat.req_type == snpr_pkg::REQ_PUSH) begin
                        mem_wr = 1'b1;
                        if (r_widx == LAST_WORD) begin
                            n_widx      = '0;
                            n_next_seq  = r_next_seq + 1'b1;
                            n_head      = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
                            if (r_held == FULL_CNT) begin
                                n_oldest = r_oldest + 1'b1;
                                n_tail   = (r_tail == LAST_SLOT) ? '0 : r_tail + 1'b1;
                            end else begin
                                n_held = r_held + 1'b1;
                            end
                            n_out_valid       = 1'b1;
                            n_out.status      = snpr_pkg::STAT_PUSHED;
                            n_out.seq_number  = r_next_seq;
                            n_out.header_word = '0;
                            n_out.data_word   = '0;
                            n_out.last        = 1'b1;
                        end else begin
                            n_widx = r_widx + 1'b1;
                        end
                    end else if (r_widx != '0 || r_held == '0) begin
                        n_out_valid       = 1'b1;
                        n_out.status      = (r_widx != '0) ? snpr_pkg::STAT_BUSY
                                                           : snpr_pkg::STAT_FUTURE;
                        n_out.seq_number  = i_in_beat.seq_request;
                        n_out.header_word = '0;
                        n_out.data_word   = '0;
                        n_out.last        = 1'b1;
                    end else begin
                        n_seq   = i_in_beat.seq_request;
                        n_fwd   = i_in_beat.seq_request - r_oldest;
                        n_state = snpr_pkg::S_CALC;
                    end
                end
            end
            snpr_pkg::S_CALC: begin
                if (in_win) begin
                    n_slot    = slot_sum[SW-1:0];
                    n_hdr     = make_header(r_seq);
                    n_rd_idx  = '0;
                    n_issuing = 1'b1;
                    n_q_vld   = 1'b0;
                    n_state   = snpr_pkg::S_STREAM;
                end else if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.status      = (r_fwd < snpr_pkg::FUTURE_LIMIT)
                                        ? snpr_pkg::STAT_FUTURE : snpr_pkg::STAT_TOO_OLD;
                    n_out.seq_number  = r_seq;
                    n_out.header_word = '0;
                    n_out.data_word   = '0;
                    n_out.last        = 1'b1;
                    n_state           = snpr_pkg::S_IDLE;
                end
            end
            snpr_pkg::S_STREAM: begin
                // RAM output register drains into the output register
                if (r_q_vld && out_free) begin
                    n_q_vld           = 1'b0;
                    n_out_valid       = 1'b1;
                    n_out.status      = snpr_pkg::STAT_OK;
                    n_out.seq_number  = r_seq;
                    n_out.header_word = r_hdr;
                    n_out.data_word   = r_mem_q;
                    n_out.last        = r_q_last;
                    if (r_q_last) begin
                        n_state = snpr_pkg::S_IDLE;
                    end
                end
                if (r_issuing && (!r_q_vld || out_free)) begin
                    mem_rd   = 1'b1;
                    n_q_vld  = 1'b1;
                    n_q_last = (r_rd_idx == LAST_WORD);
                    if (r_rd_idx == LAST_WORD) begin
                        n_issuing = 1'b0;
                    end else begin
                        n_rd_idx = r_rd_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = snpr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= snpr_pkg::S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_held      <= '0;
            r_next_seq  <= '0;
            r_oldest    <= '0;
            r_widx      <= '0;
            r_issuing   <= 1'b0;
            r_q_vld     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_held      <= n_held;
            r_next_seq  <= n_next_seq;
            r_oldest    <= n_oldest;
            r_widx      <= n_widx;
            r_issuing   <= n_issuing;
            r_q_vld     <= n_q_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq    <= n_seq;
        r_fwd    <= n_fwd;
        r_slot   <= n_slot;
        r_hdr    <= n_hdr;
        r_rd_idx <= n_rd_idx;
        r_q_last <= n_q_last;
        r_out    <= n_out;
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

FILE: sv/snpr_checker.sv
module snpr_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input snpr_pkg::t_out_beat o_out_beat
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_beat))
        else $error("output beat changed while stalled");

    a_short_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.status != snpr_pkg::STAT_OK |->
            o_out_beat.last && o_out_beat.header_word == '0 && o_out_beat.data_word == '0)
        else $error("non-ok beat not a single zeroed last beat");

    a_stream_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_beat.status == snpr_pkg::STAT_OK
            && !o_out_beat.last |=>
            !o_out_valid || (o_out_beat.status == snpr_pkg::STAT_OK
                && $stable(o_out_beat.seq_number) && $stable(o_out_beat.header_word)))
        else $error("record stream broken");

    a_stream_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.status == snpr_pkg::STAT_OK && !o_out_beat.last
            |-> !o_in_ready)
        else $error("input taken mid record stream");

endmodule

bind seq_numbered_packet_ring snpr_checker u_snpr_checker (.*);
